// ===== design/assert_macros.svh =====
// Assertion macros shared by the convolution block.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Plain invariant, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== design/conv3_pkg.sv =====
// Types and constants for the 3x3 RGB convolution block.
// No dependencies.
package conv3_pkg;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   typedef struct packed {
      logic [11:0] centre_row;
      logic [9:0]  centre_col;
      logic [7:0]  blue_out;
      logic [7:0]  green_out;
      logic [7:0]  red_out;
   } rsp_type;

   localparam logic [2:0] CSR_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_DIVISOR = 3'd1;
   localparam logic [2:0] CSR_KTOP    = 3'd2;
   localparam logic [2:0] CSR_KMID    = 3'd3;
   localparam logic [2:0] CSR_KBOT    = 3'd4;

   // 9 * 255 * 128 needs 19 bits of magnitude plus sign
   localparam int ACC_W = 20;

   // lane status passed to the merging stage
   typedef struct packed {
      logic       busy;
      logic       done;
   } lane_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // top-level item sequencing
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SHIFT = 3'b010,
      PH_LANES = 3'b100
   } phase_type;

endpackage

// ===== design/conv3_lane.sv =====
// One colour lane: weighted sum over the window, then a restoring divide
// and clamp. Depends on conv3_pkg.
module conv3_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [71:0]               samples,
   input  logic [71:0]               coefs,
   input  logic [7:0]                divisor,
   output conv3_pkg::lane_stat_type  stat,
   output logic [7:0]                result
);
   localparam int AW = conv3_pkg::ACC_W;

   logic [3:0]         step_ff, step_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0]      rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]         bit_ff, bit_in;
   logic               neg_ff, neg_in;
   conv3_pkg::state_type st_ff, st_in;
   logic [7:0]         d;
   logic signed [8:0]  s9;
   logic signed [8:0]  c9;
   logic signed [17:0] prod;
   logic [AW:0]        trial;
   logic [AW-1:0]      mag;

   always_comb begin
      d    = (divisor == 8'd0) ? 8'd1 : divisor;
      s9   = $signed({1'b0, samples[step_ff[3:0]*8 +: 8]});
      c9   = $signed({coefs[step_ff*8+7], coefs[step_ff*8 +: 8]});
      prod = s9 * c9;
      mag  = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
      trial = {rem_ff, quo_ff[AW-1]} - {{(AW-7){1'b0}}, d};
      st_in = st_ff; step_in = step_ff; acc_in = acc_ff;
      rem_in = rem_ff; quo_in = quo_ff; bit_in = bit_ff; neg_in = neg_ff;
      unique case (st_ff)
         conv3_pkg::ST_IDLE: begin
            if (start) begin
               st_in = conv3_pkg::ST_SUM; step_in = 4'd0; acc_in = '0;
            end
         end
         conv3_pkg::ST_SUM: begin
            acc_in = acc_ff + AW'(prod);
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) st_in = conv3_pkg::ST_OUT;
         end
         conv3_pkg::ST_OUT: begin
            neg_in = acc_ff[AW-1]; quo_in = mag; rem_in = '0;
            bit_in = 5'(AW); st_in = conv3_pkg::ST_DIV;
         end
         conv3_pkg::ST_DIV: begin
            if (trial[AW]) begin
               rem_in = trial[AW-1:0] + {{(AW-8){1'b0}}, d};
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end else begin
               rem_in = trial[AW-1:0];
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd1) st_in = conv3_pkg::ST_IDLE;
         end
         default: st_in = conv3_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= conv3_pkg::ST_IDLE;
         step_ff <= '0; bit_ff <= '0;
      end else begin
         st_ff <= st_in; step_ff <= step_in; bit_ff <= bit_in;
      end
      acc_ff <= acc_in; rem_ff <= rem_in; quo_ff <= quo_in; neg_ff <= neg_in;
   end

   assign stat.busy = (st_ff != conv3_pkg::ST_IDLE);
   assign stat.done = (st_ff == conv3_pkg::ST_DIV) && (bit_ff == 5'd1);
   // final quotient is quo_in on the done cycle; registered next cycle
   assign result = neg_ff ? 8'd0 : ((quo_ff > AW'(255)) ? 8'd255 : quo_ff[7:0]);
endmodule

// ===== design/convolution_3x3_rgb_top.sv =====
// Top level of the 3x3 RGB convolution block: line stores, window, lanes.
// Depends on conv3_pkg, conv3_lane and assert_macros.svh.
//
// A pixel item that gives a result passes, from acceptance to the next
// acceptance, through a window update, nine multiply-accumulate steps in
// each colour lane, a set-up step, a 20-step restoring divider, a latch of
// the quotient and a load of the output register, the three lanes running
// side by side; edge pixels that give no result have the window update
// only. The result waits in an output register while the next item is taken;
// a new result that finds that register still full waits until it is taken.
// Line stores are memories read before the window update; no clearing pass.
`include "assert_macros.svh"
module convolution_3x3_rgb_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  conv3_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output conv3_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [10:0] width_ff;
   logic [7:0]  div_ff;
   logic [23:0] k_ff [3];
   logic [23:0] older_mem [MAX_WIDTH];
   logic [23:0] newer_mem [MAX_WIDTH];
   logic [23:0] win_ff [9];
   logic [CW-1:0] col_ff, col_in, cur_col_ff;
   logic [RW-1:0] row_ff, row_in, cur_row_ff;
   logic [23:0] pix_ff, top_ff, mid_ff;
   conv3_pkg::phase_type phase_ff;
   logic        rsp_valid_ff;
   conv3_pkg::rsp_type rsp_ff;
   logic [71:0] smp [3];
   logic [71:0] coefs;
   conv3_pkg::lane_stat_type stat [3];
   logic [7:0]  res [3];
   logic        start, emit, load_rsp;
   logic [13:0] w_eff;
   logic [CW-1:0] rd_col;
   logic        done_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd1024; div_ff <= 8'd1;
         k_ff[0] <= '0; k_ff[1] <= 24'h00FF00; k_ff[2] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            conv3_pkg::CSR_WIDTH:   width_ff <= csr_data[10:0];
            conv3_pkg::CSR_DIVISOR: div_ff <= csr_data[7:0];
            conv3_pkg::CSR_KTOP:    k_ff[0] <= csr_data;
            conv3_pkg::CSR_KMID:    k_ff[1] <= csr_data;
            conv3_pkg::CSR_KBOT:    k_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = (phase_ff == conv3_pkg::PH_IDLE);
   assign rd_col = req_data.frame_start ? '0 : col_ff;

   always_comb begin
      w_eff = {3'b000, width_ff};
      if (w_eff < 14'd3) w_eff = 14'd3;
      if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
      col_in = cur_col_ff + CW'(1);
      row_in = cur_row_ff;
      if (14'(cur_col_ff) + 14'd1 >= w_eff) begin
         col_in = '0;
         if (cur_row_ff < RW'(MAX_HEIGHT - 1)) row_in = cur_row_ff + RW'(1);
      end
   end

   assign emit  = (cur_col_ff >= CW'(2)) && (cur_row_ff >= RW'(2));
   assign start = (phase_ff == conv3_pkg::PH_SHIFT) && emit;
   assign load_rsp = (phase_ff == conv3_pkg::PH_LANES) && done_ff &&
                     (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         top_ff <= older_mem[rd_col];
         mid_ff <= newer_mem[rd_col];
         pix_ff <= {req_data.blue_in, req_data.green_in, req_data.red_in};
      end
      if (phase_ff == conv3_pkg::PH_SHIFT) begin
         older_mem[cur_col_ff] <= mid_ff;
         newer_mem[cur_col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= conv3_pkg::PH_IDLE; col_ff <= '0; row_ff <= '0;
         rsp_valid_ff <= 1'b0; done_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         // lane result stays put until the next start, so hold the flag
         if (stat[0].done) done_ff <= 1'b1;
         else if (load_rsp) done_ff <= 1'b0;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (phase_ff)
            conv3_pkg::PH_IDLE: if (req_valid && req_ready) begin
               phase_ff <= conv3_pkg::PH_SHIFT;
               cur_col_ff <= rd_col;
               cur_row_ff <= req_data.frame_start ? '0 : row_ff;
            end
            conv3_pkg::PH_SHIFT: begin
               win_ff[0] <= win_ff[1]; win_ff[1] <= win_ff[2]; win_ff[2] <= top_ff;
               win_ff[3] <= win_ff[4]; win_ff[4] <= win_ff[5]; win_ff[5] <= mid_ff;
               win_ff[6] <= win_ff[7]; win_ff[7] <= win_ff[8]; win_ff[8] <= pix_ff;
               col_ff <= col_in; row_ff <= row_in;
               phase_ff <= emit ? conv3_pkg::PH_LANES : conv3_pkg::PH_IDLE;
            end
            conv3_pkg::PH_LANES: if (load_rsp) begin
               phase_ff <= conv3_pkg::PH_IDLE;
            end
            default: phase_ff <= conv3_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.red_out <= res[0]; rsp_ff.green_out <= res[1];
         rsp_ff.blue_out <= res[2];
         rsp_ff.centre_col <= 10'(cur_col_ff - CW'(1));
         rsp_ff.centre_row <= 12'(cur_row_ff - RW'(1));
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            coefs[(r*3+c)*8 +: 8] = k_ff[r][c*8 +: 8];
      for (int ch = 0; ch < 3; ch++)
         for (int i = 0; i < 9; i++)
            smp[ch][i*8 +: 8] = win_ff[i][ch*8 +: 8];
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      conv3_lane u_lane (
         .clock(clock), .reset(reset), .start(start), .samples(smp[g]),
         .coefs(coefs), .divisor(div_ff), .stat(stat[g]), .result(res[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPL(a_lanes_agree, clock, reset, stat[0].busy == stat[2].busy, "lanes out of step")
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, !(req_ready && stat[1].busy), "accept while busy")
   `ASSERT_ALWAYS(a_phase_onehot, clock, reset || $onehot(phase_ff), "bad phase")
endmodule

// ===== bench/conv3_checker.sv =====
// Checker for the 3x3 RGB convolution block: tracks registers, predicts results per item.
// Depends on conv3_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 100ps
module conv3_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  conv3_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  conv3_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   output int                 error_count,
   output int                 pending_count
);

   logic [10:0] image_width;
   logic [7:0]  divisor;
   logic [23:0] kernel_rows [3];
   logic [23:0] older_line [MAX_WIDTH];
   logic [23:0] newer_line [MAX_WIDTH];
   logic [23:0] window [9];
   int          column_count;
   int          row_count;
   conv3_pkg::rsp_type pixel_results_q [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic logic [7:0] filter_channel(int ch);
      int sum, q, d, coef, samp;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef = int'($signed(kernel_rows[r][8*c +: 8]));
            samp = int'(window[r*3 + c][8*ch +: 8]);
            sum += coef * samp;
         end
      end
      d = (divisor == 0) ? 1 : int'(divisor);
      // int division truncates toward zero already
      q = sum / d;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   task automatic predict_pixel(conv3_pkg::req_type px);
      logic [23:0] pix, top, mid;
      int          col, row, w;
      conv3_pkg::rsp_type res;
      pix = {px.blue_in, px.green_in, px.red_in};
      if (px.frame_start) begin
         column_count = 0;
         row_count    = 0;
      end
      col = column_count;
      row = row_count;
      w = int'(image_width);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      top = older_line[col % MAX_WIDTH];
      mid = newer_line[col % MAX_WIDTH];
      window[0] = window[1]; window[1] = window[2]; window[2] = top;
      window[3] = window[4]; window[4] = window[5]; window[5] = mid;
      window[6] = window[7]; window[7] = window[8]; window[8] = pix;
      older_line[col % MAX_WIDTH] = mid;
      newer_line[col % MAX_WIDTH] = pix;
      if (col >= 2 && row >= 2) begin
         res.red_out    = filter_channel(0);
         res.green_out  = filter_channel(1);
         res.blue_out   = filter_channel(2);
         res.centre_col = 10'(col - 1);
         res.centre_row = 12'(row - 1);
         pixel_results_q.push_back(res);
      end
      if (col + 1 >= w) begin
         column_count = 0;
         if (row_count < MAX_HEIGHT - 1) row_count++;
      end else begin
         column_count = col + 1;
      end
   endtask

   task automatic compare_result(conv3_pkg::rsp_type got);
      conv3_pkg::rsp_type want;
      if (pixel_results_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected result item: %h", got);
         return;
      end
      want = pixel_results_q.pop_front();
      if (got.red_out != want.red_out || got.green_out != want.green_out ||
          got.blue_out != want.blue_out || got.centre_col != want.centre_col ||
          got.centre_row != want.centre_row) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch: expected rgb %h %h %h col %0d row %0d",
                     want.red_out, want.green_out, want.blue_out,
                     want.centre_col, want.centre_row);
            $display("          got      rgb %h %h %h col %0d row %0d",
                     got.red_out, got.green_out, got.blue_out,
                     got.centre_col, got.centre_row);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         image_width    = 11'd1024;
         divisor        = 8'd1;
         kernel_rows[0] = 24'h0;
         kernel_rows[1] = 24'h00FF00;
         kernel_rows[2] = 24'h0;
         for (int i = 0; i < 9; i++) window[i] = '0;
         column_count = 0;
         row_count    = 0;
         pixel_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               conv3_pkg::CSR_WIDTH:   image_width    = csr_data[10:0];
               conv3_pkg::CSR_DIVISOR: divisor        = csr_data[7:0];
               conv3_pkg::CSR_KTOP:    kernel_rows[0] = csr_data;
               conv3_pkg::CSR_KMID:    kernel_rows[1] = csr_data;
               conv3_pkg::CSR_KBOT:    kernel_rows[2] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_pixel(req_data);
      end
      pending_count = pixel_results_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: clock, reset, pixel and register stimulus, final verdict.
// Depends on conv3_pkg, convolution_3x3_rgb_top and conv3_checker.
`timescale 1ns / 100ps
module testbench;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   conv3_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   conv3_pkg::rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = conv3_pkg::CSR_WIDTH;
   logic [23:0] csr_data = '0;
   int          error_count, pending_count;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          rsp_stall = 0;
   int          rsp_roll;
   bit          quiet = 1'b0;

   convolution_3x3_rgb_top u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   conv3_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .error_count, .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (quiet || rsp_roll < 60) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall <= pick_gap();
         end
      end
   end

   function automatic logic [7:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // valid stays high across back-to-back items; caller lowers it at the end
   task automatic send_pixel(logic fs);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{frame_start: fs, blue_in: rand_sample(), green_in: rand_sample(),
                    red_in: rand_sample()};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // ends any register write burst before the pixels start
   task automatic send_pixels(int count, bit start_frame, bit noise);
      csr_valid <= 1'b0;
      for (int i = 0; i < count; i++)
         send_pixel((start_frame && i == 0) || (noise && $urandom_range(0, 59) == 0));
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // an edge item may still be in flight
      repeat (60) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes; send_pixels lowers it
   task automatic csr_write(logic [2:0] idx, logic [23:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_kernel();
      logic [23:0] k;
      if ($urandom_range(0, 9) < 4) return 24'($urandom);
      for (int c = 0; c < 3; c++) k[8*c +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
      return k;
   endfunction

   task automatic set_filter(logic [7:0] div, logic [23:0] kt, logic [23:0] km,
                             logic [23:0] kb);
      csr_write(conv3_pkg::CSR_DIVISOR, {16'h0, div});
      csr_write(conv3_pkg::CSR_KTOP, kt);
      csr_write(conv3_pkg::CSR_KMID, km);
      csr_write(conv3_pkg::CSR_KBOT, kb);
   endtask

   initial begin
      int w, rows, r;
      logic [7:0] div;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset kernel on a minimal image
      csr_write(conv3_pkg::CSR_WIDTH, 24'd3);
      send_pixels(9, 1'b1, 1'b0);
      wait_idle();
      // saturate high, then low with divisor zero
      set_filter(8'd1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
      send_pixels(9, 1'b1, 1'b0);
      wait_idle();
      set_filter(8'd0, 24'h808080, 24'h808080, 24'h808080);
      send_pixels(6, 1'b1, 1'b0);
      wait_idle();

      // width lowered in the middle of a row
      set_filter(8'd4, 24'h010201, 24'h020402, 24'h010201);
      csr_write(conv3_pkg::CSR_WIDTH, 24'd12);
      send_pixels(34, 1'b1, 1'b0);
      wait_idle();
      csr_write(conv3_pkg::CSR_WIDTH, 24'd5);
      send_pixels(11, 1'b0, 1'b0);
      wait_idle();

      // out-of-range widths
      csr_write(conv3_pkg::CSR_WIDTH, 24'd2047);
      send_pixels(20, 1'b1, 1'b0);
      wait_idle();
      csr_write(conv3_pkg::CSR_WIDTH, 24'd0);
      set_filter(8'd255, 24'hFFFFFF, 24'h000000, 24'h7F0080);
      send_pixels(12, 1'b1, 1'b0);
      wait_idle();

      // random phases
      while (items_sent < 1050) begin
         r = $urandom_range(0, 99);
         w = (r < 70) ? $urandom_range(3, 8) : (r < 95) ? $urandom_range(9, 24)
                                                       : $urandom_range(40, 64);
         rows = $urandom_range(3, 6);
         r = $urandom_range(0, 99);
         div = (r < 40) ? 8'd1 : (r < 50) ? 8'd255 : (r < 53) ? 8'd0
                                                   : 8'($urandom_range(1, 255));
         quiet = ($urandom_range(0, 4) == 0);
         csr_write(conv3_pkg::CSR_WIDTH, 24'(w));
         set_filter(div, rand_kernel(), rand_kernel(), rand_kernel());
         send_pixels(w * rows, 1'b1, 1'b1);
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
